/* rtl/core/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg
// Shared types and constants of the Modbus RTU reply checker: opcodes,
// status codes, register indexes, CRC constants and the command that passes
// from the front end to the back end.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  // Default capacity of the frame store, in bytes.
  localparam int MAX_FRAME_DEF = 64;
  // Largest payload that a reply can be accepted with.
  localparam int MAX_DATA      = 60;

  // Input opcodes.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_FINAL   = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_REPLY = 3'd1;
  localparam logic [2:0] ST_CRC      = 3'd2;
  localparam logic [2:0] ST_ADDRESS  = 3'd3;
  localparam logic [2:0] ST_FUNCTION = 3'd4;
  localparam logic [2:0] ST_EXCEPT   = 3'd5;
  localparam logic [2:0] ST_LENGTH   = 3'd6;

  // Configuration register indexes.
  localparam int         CFG_IDX_W    = 2;
  localparam logic [1:0] REG_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_DATA_LEN = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_ADDRESS  = 8'h01;
  localparam logic [7:0] RST_FUNCTION = 8'h03;
  localparam logic [5:0] RST_DATA_LEN = 6'd0;

  // Reflected CRC-16 constants.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_LSB  = 16'h0001;
  // Offset that marks an exception reply in the function code.
  localparam logic [8:0]  EXC_FLAG = 9'h080;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic       is_drain;  // 1: send the payload bytes, 0: send one status item
    logic [2:0] status;
    logic [7:0] exc;
    logic [5:0] len;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage

/* rtl/core/mbrc_if.sv */
// ----------------------------------------------------------------------------
// mbrc_if
// Valid/ready channel interfaces of the reply checker: received bytes,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface mbrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mbrc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] exception_code;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last;

  modport source (output valid, output status, output exception_code,
                  output data_byte, output data_valid, output last, input ready);
  modport sink   (input valid, input status, input exception_code,
                  input data_byte, input data_valid, input last, output ready);
endinterface

interface mbrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/mbrc_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mbrc_cmd_fifo
// Two-entry command queue between the front end and the back end, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module mbrc_cmd_fifo
  import mbrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic head_valid,
  output logic full
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/mbrc_front.sv */
// ----------------------------------------------------------------------------
// mbrc_front
// Front end: holds the configuration, takes received bytes, runs the CRC,
// writes the bytes to the frame store and classifies each finished frame
// into a command for the back end.
// ----------------------------------------------------------------------------
module mbrc_front
  import mbrc_pkg::*;
#(
  parameter int  MAX_FRAME = MAX_FRAME_DEF,
  localparam int AW        = $clog2(MAX_FRAME),
  localparam int CW        = $clog2(MAX_FRAME + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Received bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_rx_byte,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // Command queue
  output logic                 push,
  output cmd_t                 push_cmd,
  input  logic                 q_full,
  // Frame store write port
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  // Back end has finished reading the store
  input  logic                 drain_done
);

  // Width wide enough for byte count and expected length plus header and CRC.
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic [7:0]    exp_addr_r;
  logic [7:0]    exp_func_r;
  logic [5:0]    exp_len_r;
  logic [15:0]   crc_r, crc_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    b0_r, b1_r, b2_r;
  logic          drain_pending_r;

  logic          accept;
  logic          is_byte;
  logic          frame_end;
  logic          room;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] len_ext;
  logic [2:0]    fin_status;
  logic [7:0]    fin_exc;

  // One CRC byte update, eight shift steps.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_LSB) != 16'h0000) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= RST_ADDRESS;
      exp_func_r <= RST_FUNCTION;
      exp_len_r  <= RST_DATA_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADDRESS:  exp_addr_r <= cfg_data;
        REG_FUNCTION: exp_func_r <= cfg_data;
        REG_DATA_LEN: exp_len_r  <= cfg_data[5:0];
        default:      ;
      endcase
    end
  end

  // The store is shared with the back end, so bytes wait while it drains.
  assign in_ready  = !drain_pending_r && !q_full;
  assign accept    = in_valid && in_ready;
  assign is_byte   = (in_opcode == OP_BYTE) || (in_opcode == OP_FINAL);
  assign frame_end = (in_opcode == OP_FINAL) || (in_opcode == OP_TIMEOUT);

  // Running CRC and byte count including the byte at the port.
  always_comb begin
    crc_nxt   = crc_step(crc_r, in_rx_byte);
    room      = (count_r < CW'(MAX_FRAME));
    count_nxt = room ? count_r + CW'(1) : count_r;
    ovf_nxt   = ovf_r || !room;
    count_ext = CMPW'(count_nxt);
    len_ext   = CMPW'(exp_len_r) + CMPW'(4);
  end

  // Checks at frame end, in order of precedence.
  always_comb begin
    fin_exc = 8'h00;
    priority if (count_ext < CMPW'(4) || crc_nxt != 16'h0000) begin
      fin_status = ST_CRC;
    end else if (b0_r != exp_addr_r) begin
      fin_status = ST_ADDRESS;
    end else if (b1_r != exp_func_r) begin
      if ({1'b0, b1_r} == ({1'b0, exp_func_r} + EXC_FLAG)) begin
        fin_status = ST_EXCEPT;
        fin_exc    = b2_r;
      end else begin
        fin_status = ST_FUNCTION;
      end
    end else if (ovf_nxt || exp_len_r > 6'(MAX_DATA) || count_ext != len_ext) begin
      fin_status = ST_LENGTH;
    end else begin
      fin_status = ST_OK;
    end
  end

  // Command towards the back end.
  always_comb begin
    push              = accept && frame_end;
    push_cmd.len      = exp_len_r;
    if (in_opcode == OP_TIMEOUT) begin
      push_cmd.is_drain = 1'b0;
      push_cmd.status   = ST_NO_REPLY;
      push_cmd.exc      = 8'h00;
    end else begin
      push_cmd.is_drain = (fin_status == ST_OK) && (exp_len_r != 6'd0);
      push_cmd.status   = fin_status;
      push_cmd.exc      = fin_exc;
    end
  end

  // Frame store write.
  assign wr_en   = accept && is_byte && room;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = in_rx_byte;

  // Frame state: cleared at frame end, advanced on every other byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept && frame_end) begin
      crc_r   <= CRC_INIT;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept && is_byte) begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Header bytes kept in registers for the checks.
  always_ff @(posedge clk) begin
    if (accept && is_byte) begin
      if (count_r == CW'(0)) b0_r <= in_rx_byte;
      if (count_r == CW'(1)) b1_r <= in_rx_byte;
      if (count_r == CW'(2)) b2_r <= in_rx_byte;
    end
  end

  // Set while a payload drain is queued or running.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_pending_r <= 1'b0;
    end else if (push && push_cmd.is_drain) begin
      drain_pending_r <= 1'b1;
    end else if (drain_done) begin
      drain_pending_r <= 1'b0;
    end
  end

endmodule

/* rtl/core/mbrc_back.sv */
// ----------------------------------------------------------------------------
// mbrc_back
// Back end: owns the frame store, takes commands from the queue and turns
// them into result items through a registered output stage.
// ----------------------------------------------------------------------------
module mbrc_back
  import mbrc_pkg::*;
#(
  parameter int  MAX_FRAME = MAX_FRAME_DEF,
  localparam int AW        = $clog2(MAX_FRAME)
) (
  input  logic          clk,
  input  logic          rst_n,
  // Frame store write port
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  // Command queue
  input  cmd_t          head,
  input  logic          head_valid,
  output logic          pop,
  output logic          drain_done,
  // Result items
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_exception_code,
  output logic [7:0]    out_data_byte,
  output logic          out_data_valid,
  output logic          out_last
);

  logic [7:0]  mem [MAX_FRAME];
  logic [7:0]  rdata_r;

  back_state_t state_r, state_nxt;
  logic [AW-1:0] rd_addr_r;
  logic [5:0]    remain_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_exc_r;
  logic [7:0]  out_data_r;
  logic        out_dv_r;
  logic        out_last_r;

  logic out_free;
  logic load_status;
  logic load_data;
  logic rd_en;
  logic start_drain;

  assign out_free = !out_valid_r || out_ready;

  // Frame store: one write port from the front end, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (head_valid && head.is_drain) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = (remain_r == 6'd1) ? BK_IDLE : BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop         = 1'b0;
    load_status = 1'b0;
    load_data   = 1'b0;
    rd_en       = 1'b0;
    start_drain = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        start_drain = head_valid && head.is_drain;
        load_status = head_valid && !head.is_drain && out_free;
        pop         = start_drain || load_status;
      end
      BK_READ: rd_en = 1'b1;
      BK_EMIT: load_data = out_free;
      default: ;
    endcase
    drain_done = load_data && (remain_r == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload read pointer; payload starts after address and function code.
  always_ff @(posedge clk) begin
    if (start_drain) begin
      rd_addr_r <= AW'(2);
      remain_r  <= head.len;
    end else if (load_data) begin
      rd_addr_r <= rd_addr_r + AW'(1);
      remain_r  <= remain_r - 6'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_status || load_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_status_r <= head.status;
      out_exc_r    <= head.exc;
      out_data_r   <= 8'h00;
      out_dv_r     <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (load_data) begin
      out_status_r <= ST_OK;
      out_exc_r    <= 8'h00;
      out_data_r   <= rdata_r;
      out_dv_r     <= 1'b1;
      out_last_r   <= (remain_r == 6'd1);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_exception_code = out_exc_r;
  assign out_data_byte      = out_data_r;
  assign out_data_valid     = out_dv_r;
  assign out_last           = out_last_r;

  // The front end must not overwrite the store while a drain is running.
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == BK_IDLE)
    else $error("frame store written during a payload drain");

  // Payload items always carry status ok and no exception code.
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dv_r) |-> (out_status_r == ST_OK && out_exc_r == 8'h00))
    else $error("payload item with non-ok status");

  // A byte is only emitted while some remain.
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT || state_r == BK_READ) |-> remain_r != 6'd0)
    else $error("drain running with no bytes left");

  // Finishing a drain returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> state_r == BK_IDLE)
    else $error("sequencer not idle after drain");

endmodule

/* rtl/core/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks a received Modbus RTU reply and delivers its payload or a status.
// ----------------------------------------------------------------------------
// Usage. Bytes of one reply enter on in_ch, one transaction each: opcode 0
// for a frame byte, 1 for the final byte, 2 for a reply timeout. Each byte
// takes one cycle while in_ch is ready; each byte updates the CRC register.
// At the final byte the frame is checked (CRC, address, function or
// exception reply, length) and a command is queued for the back end.
// Results leave on out_ch through an output register. A status item
// passes through the command queue and the output register after the
// final byte or timeout is taken. Payload bytes of a good reply are read
// from the frame store one at a time, each by a store read and then an
// output load; in_ch holds ready low until the last payload byte has left
// the store. Configuration is to be written through cfg_ch only while
// the block is idle; the block does not enforce it. cfg_ch is always ready.
// A stalled receiver holds the output register; the front end keeps taking
// bytes until the two-entry command queue fills or a payload drain is due.
// Reset (rst_n low, synchronous) restores the register defaults, empties
// the queue and starts a fresh frame; the store needs no clearing.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker
  import mbrc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mbrc_in_if.sink    in_ch,
  mbrc_out_if.source out_ch,
  mbrc_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_FRAME);

  cmd_t          push_cmd;
  cmd_t          head;
  logic          push;
  logic          pop;
  logic          head_valid;
  logic          q_full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          drain_done;

  mbrc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .in_rx_byte (in_ch.rx_byte),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .drain_done (drain_done)
  );

  mbrc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  mbrc_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .head               (head),
    .head_valid         (head_valid),
    .pop                (pop),
    .drain_done         (drain_done),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_exception_code (out_ch.exception_code),
    .out_data_byte      (out_ch.data_byte),
    .out_data_valid     (out_ch.data_valid),
    .out_last           (out_ch.last)
  );

endmodule

/* tb/mbrc_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_tb_pkg
// Verification types and helpers shared by the reply monitor and the
// testbench top: the result item, the codes the design package leaves out
// and the reflected CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrc_tb_pkg;
  import mbrc_pkg::*;

  // Opcode that the block must ignore without any effect.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register index that does not select any register.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } reply_item_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* tb/mbrc_reply_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrc_reply_monitor
// Watches the byte, result and configuration channels of the reply checker.
// It keeps its own copy of the frame state and registers, works out the
// result items of every accepted byte and compares each result transaction
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mbrc_reply_monitor
  import mbrc_pkg::*;
  import mbrc_tb_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mbrc_in_if          in_mon,
  mbrc_out_if         out_mon,
  mbrc_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  // Register copies.
  logic [7:0] want_address;
  logic [7:0] want_function;
  logic [5:0] want_len;

  // Frame state copies.
  logic [15:0] frame_crc;
  int unsigned frame_len;
  logic        frame_overflow;
  logic [7:0]  frame_copy [MAX_FRAME];

  reply_item_t expected_items [$];
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  function automatic string describe(input reply_item_t it);
    return $sformatf("status=%0d exc=%02h data=%02h dv=%0b last=%0b",
                     it.status, it.exception_code, it.data_byte,
                     it.data_valid, it.last);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function void start_frame();
    frame_crc      = CRC_INIT;
    frame_len      = 0;
    frame_overflow = 1'b0;
  endfunction

  function void expect_item(input logic [2:0] st, input logic [7:0] exc,
                            input logic [7:0] db, input logic dv,
                            input logic lst);
    reply_item_t it;
    it = {st, exc, db, dv, lst};
    expected_items.push_back(it);
  endfunction

  // Work out the result items caused by one accepted byte transaction.
  function void predict_reply(input logic [1:0] op, input logic [7:0] b);
    logic [2:0] st;
    logic [7:0] exc;
    if (op == OP_UNUSED) begin
      return;
    end
    if (op == OP_TIMEOUT) begin
      start_frame();
      expect_item(ST_NO_REPLY, 8'h00, 8'h00, 1'b0, 1'b1);
      return;
    end

    // Every byte enters the CRC; only the first MAX_FRAME are kept.
    frame_crc = crc16_update(frame_crc, b);
    if (frame_len < MAX_FRAME) begin
      frame_copy[frame_len] = b;
      frame_len++;
    end else begin
      frame_overflow = 1'b1;
    end
    if (op == OP_BYTE) begin
      return;
    end

    // Frame end: the checks run in a fixed order.
    exc = 8'h00;
    if (frame_len < 4 || frame_crc != 16'h0000) begin
      st = ST_CRC;
    end else if (frame_copy[0] != want_address) begin
      st = ST_ADDRESS;
    end else if (frame_copy[1] != want_function) begin
      if ({1'b0, frame_copy[1]} == ({1'b0, want_function} + EXC_FLAG)) begin
        st  = ST_EXCEPT;
        exc = frame_copy[2];
      end else begin
        st = ST_FUNCTION;
      end
    end else if (frame_overflow || want_len > MAX_DATA ||
                 (frame_len - 4) != int'(want_len)) begin
      st = ST_LENGTH;
    end else begin
      st = ST_OK;
    end

    if (st != ST_OK || want_len == 6'd0) begin
      expect_item(st, exc, 8'h00, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < int'(want_len); i++) begin
        expect_item(ST_OK, 8'h00, frame_copy[i + 2], 1'b1,
                    i == int'(want_len) - 1);
      end
    end
    start_frame();
  endfunction

  // Sample all channels at the clock edge, compare first, then predict.
  always @(posedge clk) begin
    reply_item_t got;
    reply_item_t want;
    if (!rst_n) begin
      want_address  = RST_ADDRESS;
      want_function = RST_FUNCTION;
      want_len      = RST_DATA_LEN;
      start_frame();
      expected_items.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.exception_code, out_mon.data_byte,
               out_mon.data_valid, out_mon.last};
        if (expected_items.size() == 0) begin
          report_mismatch({"unexpected result ", describe(got)});
        end else begin
          want = expected_items.pop_front();
          if (got !== want) begin
            report_mismatch({"got ", describe(got), ", expected ", describe(want)});
          end
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ADDRESS:  want_address  = cfg_mon.data;
          REG_FUNCTION: want_function = cfg_mon.data;
          REG_DATA_LEN: want_len      = cfg_mon.data[5:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_reply(in_mon.opcode, in_mon.rx_byte);
      end
    end
    pending_count <= expected_items.size();
  end

endmodule

/* tb/modbus_rtu_response_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_tb
// Drives the reply checker with a short directed set of replies and then
// phases of random replies under changing register settings, with random
// idling on both channels, a quiet stretch and one long receiver hold-off.
// The reply monitor predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_tb;
  import mbrc_pkg::*;
  import mbrc_tb_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 430;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_PHASE = 5;
  localparam int QUIET_PHASE    = 4;
  localparam int CYCLE_LIMIT    = 200000;

  typedef enum int {
    K_GOOD,
    K_BAD_LEN,
    K_EXCEPTION,
    K_BAD_ADDR,
    K_BAD_FUNC,
    K_BAD_CRC,
    K_SHORT,
    K_TIMEOUT,
    K_OVERLONG,
    K_NOISE
  } reply_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  mbrc_in_if  in_ch ();
  mbrc_out_if out_ch ();
  mbrc_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned pending_count;

  // Settings last written, used to shape well-formed replies.
  logic [7:0] cur_address  = RST_ADDRESS;
  logic [7:0] cur_function = RST_FUNCTION;
  logic [5:0] cur_len      = RST_DATA_LEN;

  logic [7:0] frame_q [$];
  bit         cut_short;
  bit         quiet    = 1'b0;
  bit         hold_arm = 1'b0;
  int         hold_count = 0;
  int         rx_items   = 0;
  int         cycle_count = 0;

  modbus_rtu_response_checker #(
    .MAX_FRAME(MAX_FRAME_DEF)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mbrc_reply_monitor #(
    .MAX_FRAME(MAX_FRAME_DEF)
  ) reply_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: one long hold-off once armed; else ready when quiet, random otherwise.
  always @(posedge clk) begin
    if (hold_arm && hold_count < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count++;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 8);
    end
  end

  // Offer one byte transaction, after a random idle gap, and wait for it.
  task automatic send_rx(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < 8) begin
      gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_UNUSED) begin
      rx_items++;
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ADDRESS:  cur_address  = value;
      REG_FUNCTION: cur_function = value;
      REG_DATA_LEN: cur_len      = value[5:0];
      default: ;
    endcase
  endtask

  // Append the CRC to the queued frame, low byte first.
  task automatic append_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) begin
      c = crc16_update(c, frame_q[i]);
    end
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic put_reply(input logic [7:0] addr, input logic [7:0] func,
                           input int n);
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(func);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    append_crc();
  endtask

  // Send the queued frame, ending with a final byte or a timeout.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_rx(OP_UNUSED, 8'($urandom_range(0, 255)));
      end
      send_rx((i == frame_q.size() - 1 && !cut_short) ? OP_FINAL : OP_BYTE,
              frame_q[i]);
    end
    if (cut_short) begin
      send_rx(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic reply_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 46)      return K_GOOD;
    else if (r < 56) return K_BAD_LEN;
    else if (r < 64) return K_EXCEPTION;
    else if (r < 70) return K_BAD_ADDR;
    else if (r < 76) return K_BAD_FUNC;
    else if (r < 84) return K_BAD_CRC;
    else if (r < 88) return K_SHORT;
    else if (r < 93) return K_TIMEOUT;
    else if (r < 97) return K_OVERLONG;
    else             return K_NOISE;
  endfunction

  // Fill the frame queue with one reply of the given kind.
  task automatic build_frame(input reply_kind_t kind);
    int n;
    cut_short = 1'b0;
    case (kind)
      K_GOOD: put_reply(cur_address, cur_function, cur_len);
      K_BAD_LEN: begin
        do n = $urandom_range(0, 12); while (n == cur_len);
        put_reply(cur_address, cur_function, n);
      end
      K_EXCEPTION: begin
        frame_q.delete();
        frame_q.push_back(cur_address);
        frame_q.push_back(cur_function + 8'h80);
        frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        append_crc();
      end
      K_BAD_ADDR:
        put_reply(cur_address ^ 8'($urandom_range(1, 255)), cur_function,
                  $urandom_range(0, 6));
      K_BAD_FUNC:
        put_reply(cur_address, cur_function ^ 8'($urandom_range(1, 255)),
                  $urandom_range(0, 6));
      K_BAD_CRC: begin
        put_reply(cur_address, cur_function, cur_len);
        n = $urandom_range(0, frame_q.size() - 1);
        frame_q[n] = frame_q[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      K_SHORT: begin
        frame_q.delete();
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      K_TIMEOUT: begin
        put_reply(cur_address, cur_function, cur_len);
        n = $urandom_range(0, frame_q.size() - 1);
        while (frame_q.size() > n) void'(frame_q.pop_back());
        cut_short = 1'b1;
      end
      K_OVERLONG: put_reply(cur_address, cur_function, $urandom_range(61, 70));
      default: begin
        frame_q.delete();
        repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // The first frame of each phase rotates through the rarer cases and a good reply.
  function automatic reply_kind_t lead_kind(input int p);
    case (p % 6)
      0:       return K_OVERLONG;
      1:       return K_EXCEPTION;
      2:       return K_BAD_LEN;
      3:       return K_TIMEOUT;
      4:       return K_BAD_CRC;
      default: return K_GOOD;
    endcase
  endfunction

  // Register settings of a phase: the extremes first, then random ones.
  task automatic configure_phase(input int p);
    int r;
    logic [5:0] len;
    case (p)
      0: begin
        cfg_write(REG_ADDRESS, 8'h00);
        cfg_write(REG_FUNCTION, 8'h00);
        cfg_write(REG_DATA_LEN, 8'h00);
      end
      1: begin
        cfg_write(REG_ADDRESS, 8'hFF);
        cfg_write(REG_FUNCTION, 8'hFF);
        cfg_write(REG_DATA_LEN, 8'h3C);
      end
      2: begin
        cfg_write(REG_ADDRESS, 8'h7F);
        cfg_write(REG_FUNCTION, 8'h7F);
        cfg_write(REG_DATA_LEN, 8'hFD);
      end
      3: begin
        cfg_write(REG_ADDRESS, 8'h80);
        cfg_write(REG_FUNCTION, 8'h80);
        cfg_write(REG_DATA_LEN, 8'hFF);
      end
      PRESSURE_PHASE: begin
        cfg_write(REG_ADDRESS, 8'($urandom_range(0, 255)));
        cfg_write(REG_FUNCTION, 8'($urandom_range(0, 127)));
        cfg_write(REG_DATA_LEN, 8'($urandom_range(4, 8)));
      end
      default: begin
        r = $urandom_range(0, 9);
        if (r < 6)       len = 6'($urandom_range(0, 8));
        else if (r == 6) len = 6'd0;
        else if (r == 7) len = 6'd60;
        else if (r == 8) len = 6'($urandom_range(61, 63));
        else             len = 6'($urandom_range(0, 63));
        cfg_write(REG_ADDRESS, 8'($urandom_range(0, 255)));
        cfg_write(REG_FUNCTION, 8'($urandom_range(0, 255)));
        cfg_write(REG_DATA_LEN, {2'($urandom_range(0, 3)), len});
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(REG_SPARE, 8'($urandom_range(0, 255)));
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every predicted result arrive, then allow for work still in flight.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int budget;
    int target;
    bit first;
    reply_kind_t kind;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_BYTE;
    in_ch.rx_byte  = 8'h00;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_ADDRESS;
    cfg_ch.data    = 8'h00;
    out_ch.ready   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed replies at the reset settings.
    cut_short = 1'b0;
    frame_q = '{8'h01, 8'h03};
    append_crc();
    send_frame();
    frame_q = '{8'h01, 8'h83, 8'h02};
    append_crc();
    send_frame();
    frame_q = '{8'h00, 8'h03};
    append_crc();
    send_frame();
    frame_q = '{8'h01, 8'h04};
    append_crc();
    send_frame();
    // Good frame with a corrupted CRC byte.
    frame_q = '{8'h01, 8'h03};
    append_crc();
    frame_q[2] = frame_q[2] ^ 8'h01;
    send_frame();
    // A single byte is too short to be a reply.
    send_rx(OP_FINAL, 8'hFF);
    send_rx(OP_TIMEOUT, 8'hFF);
    send_rx(OP_UNUSED, 8'h00);
    finish_phase();

    // Random replies in phases of changing settings.
    target = rx_items + RANDOM_ITEMS;
    phase  = 0;
    while (rx_items < target) begin
      configure_phase(phase);
      quiet <= (phase == QUIET_PHASE);
      if (phase == PRESSURE_PHASE) begin
        hold_arm <= 1'b1;
      end
      budget = rx_items + $urandom_range(40, 80);
      first  = 1'b1;
      while (rx_items < budget && rx_items < target) begin
        if (phase == PRESSURE_PHASE) begin
          kind = K_GOOD;
        end else if (first) begin
          kind = lead_kind(phase);
        end else begin
          kind = pick_kind();
        end
        build_frame(kind);
        send_frame();
        first = 1'b0;
      end
      finish_phase();
      phase++;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* modbus_rtu_response_checker.f */
rtl/core/mbrc_pkg.sv
rtl/core/mbrc_if.sv
rtl/core/mbrc_cmd_fifo.sv
rtl/core/mbrc_front.sv
rtl/core/mbrc_back.sv
rtl/core/modbus_rtu_response_checker.sv
tb/mbrc_tb_pkg.sv
tb/mbrc_reply_monitor.sv
tb/modbus_rtu_response_checker_tb.sv
